### src/ttc_pkg.sv
`timescale 1ns / 1ps
package ttc_pkg;

    localparam int TEXEL_W      = 8;
    localparam int PAIR_W       = 16;
    localparam int WORD_ADDR_W  = 19;
    localparam int LOG_W        = 4;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_WIDTH_LOG2  = 1'b0;
    localparam logic REG_HEIGHT_LOG2 = 1'b1;

    localparam logic [LOG_W-1:0] WIDTH_LOG2_RST  = 4'd6;
    localparam logic [LOG_W-1:0] HEIGHT_LOG2_RST = 4'd6;

    typedef struct packed {
        logic [TEXEL_W-1:0] texel;
        logic               frame_start;
    } t_in_item;

    typedef struct packed {
        logic [WORD_ADDR_W-1:0] word_address;
        logic [PAIR_W-1:0]      texel_pair;
        logic                   frame_done;
    } t_out_item;

endpackage

### src/ttc_addr_gen.sv
`timescale 1ns / 1ps
module ttc_addr_gen #(
    parameter int CNT_W = 10
) (
    input  logic [CNT_W-1:0]               i_x,
    input  logic [CNT_W-1:0]               i_ye,
    input  logic [ttc_pkg::LOG_W-1:0]      i_lmin,
    output logic [ttc_pkg::WORD_ADDR_W-1:0] o_addr
);
    import ttc_pkg::*;

    logic [CNT_W-1:0]   mask;
    logic [CNT_W-1:0]   xm;
    logic [CNT_W-1:0]   yh;
    logic [2*CNT_W-1:0] inner;
    logic [CNT_W:0]     blk;
    logic [LOG_W:0]     shamt;

    assign mask  = ~({CNT_W{1'b1}} << i_lmin);
    assign xm    = i_x & mask;
    assign yh    = (i_ye & mask) >> 1;
    assign blk   = {1'b0, i_x >> i_lmin} + {1'b0, i_ye >> i_lmin};
    assign shamt = {i_lmin, 1'b0} - (LOG_W + 1)'(1);

    // interleave: column bits even, half-row bits odd
    always_comb begin
        for (int i = 0; i < CNT_W; i++) begin
            inner[2*i]   = xm[i];
            inner[2*i+1] = yh[i];
        end
    end

    assign o_addr = WORD_ADDR_W'(inner) + (WORD_ADDR_W'(blk) << shamt);

endmodule

### src/texture_twiddle_converter.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------------
// texel in  | input     | i_in_valid / o_in_stall   | i_in_data  (texel, frame_start)
// word out  | output    | o_out_valid / i_out_stall | o_out_data (word_address,
//           |           |                           |   texel_pair, frame_done)
// config    | input     | APB psel/penable/pwrite   | width_log2 @0, height_log2 @4
//
// One texel transaction per cycle, sustained while o_in_stall is low. An odd-row texel
// yields its word via the pending stage (alongside the line-buffer read), then the output register.
// Reset is synchronous; it clears the counters, the valid flags and the registers
// (both log2 sizes to 6). The line buffer is not cleared and needs no clearing pass.
// A stalled output holds its word; the pending stage behind it still accepts one more
// texel, and the input stalls only when both stages are full and the output is stalled.
module texture_twiddle_converter #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // texel input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ttc_pkg::t_in_item              i_in_data,
    // word output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ttc_pkg::t_out_item             o_out_data,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ttc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ttc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ttc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ttc_pkg::*;

    // largest power-of-two side that fits within MAX_SIDE
    localparam int CNT_W     = $clog2(MAX_SIDE + 1) - 1;
    localparam int BUF_DEPTH = 1 << CNT_W;
    localparam logic [LOG_W-1:0] LOG_MAX = LOG_W'(CNT_W);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [LOG_W-1:0] r_width_log2;
    logic [LOG_W-1:0] r_height_log2;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_log2  <= WIDTH_LOG2_RST;
            r_height_log2 <= HEIGHT_LOG2_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH_LOG2:  r_width_log2  <= pwdata[LOG_W-1:0];
                REG_HEIGHT_LOG2: r_height_log2 <= pwdata[LOG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH_LOG2:  prdata = APB_DATA_W'(r_width_log2);
            REG_HEIGHT_LOG2: prdata = APB_DATA_W'(r_height_log2);
            default:         prdata = '0;
        endcase
    end

    // Clamp a log2 size into 1..log2(MAX_SIDE)
    function automatic logic [LOG_W-1:0] clamp_log2(input logic [LOG_W-1:0] l);
        logic [LOG_W-1:0] r;
        r = l;
        if (l < LOG_W'(1)) begin
            r = LOG_W'(1);
        end else if (l > LOG_MAX) begin
            r = LOG_MAX;
        end
        return r;
    endfunction

    logic [LOG_W-1:0] lw;
    logic [LOG_W-1:0] lh;
    logic [LOG_W-1:0] lmin;
    logic [CNT_W-1:0] wmask;
    logic [CNT_W-1:0] hmask;

    assign lw    = clamp_log2(r_width_log2);
    assign lh    = clamp_log2(r_height_log2);
    assign lmin  = (lw < lh) ? lw : lh;
    assign wmask = ~({CNT_W{1'b1}} << lw);
    assign hmask = ~({CNT_W{1'b1}} << lh);

    // ---------------------------------------------------------------------
    // Handshake and pipeline control
    // ---------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic in_acc;
    logic out_load;

    // Stall only when the pending stage is full and cannot drain
    assign o_in_stall  = r_s1_valid && r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_load    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;

    // ---------------------------------------------------------------------
    // Column and row counters; wrap stale values before use
    // ---------------------------------------------------------------------
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic [CNT_W-1:0] x;
    logic [CNT_W-1:0] y;
    logic [CNT_W-1:0] ye;
    logic             odd_row;
    logic             last_word;

    always_comb begin
        x = r_col;
        y = r_row;
        if (i_in_data.frame_start || ((r_col >> lw) != '0)) begin
            x = '0;
        end
        if (i_in_data.frame_start || ((r_row >> lh) != '0)) begin
            y = '0;
        end
        // advance along the row, then to the next row, then back to the top
        n_col = x + CNT_W'(1);
        n_row = y;
        if (x == wmask) begin
            n_col = '0;
            n_row = (y == hmask) ? '0 : y + CNT_W'(1);
        end
    end

    assign odd_row   = y[0];
    assign ye        = y & ~CNT_W'(1);
    assign last_word = (x == wmask) && (y == hmask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------------------------------------------------------------
    // Line buffer: even rows write, odd rows read the same column.
    // A column is always written on an earlier transaction than its read, so the
    // write has landed before the read; no forwarding path is needed.
    // ---------------------------------------------------------------------
    logic [TEXEL_W-1:0] r_mem [BUF_DEPTH];
    logic [TEXEL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (in_acc && !odd_row) begin
            r_mem[x] <= i_in_data.texel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && odd_row) begin
            r_rd_data <= r_mem[x];
        end
    end

    // ---------------------------------------------------------------------
    // Twiddled address
    // ---------------------------------------------------------------------
    logic [WORD_ADDR_W-1:0] addr;

    ttc_addr_gen #(
        .CNT_W (CNT_W)
    ) u_addr_gen (
        .i_x    (x),
        .i_ye   (ye),
        .i_lmin (lmin),
        .o_addr (addr)
    );

    // ---------------------------------------------------------------------
    // Pending stage: waits for the line-buffer read data
    // ---------------------------------------------------------------------
    logic [WORD_ADDR_W-1:0] r_s1_addr;
    logic [TEXEL_W-1:0]     r_s1_texel;
    logic                   r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= odd_row;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && odd_row) begin
            r_s1_addr  <= addr;
            r_s1_texel <= i_in_data.texel;
            r_s1_last  <= last_word;
        end
    end

    // ---------------------------------------------------------------------
    // Output register: hold while stalled
    // ---------------------------------------------------------------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.word_address <= r_s1_addr;
            r_out.texel_pair   <= {r_s1_texel, r_rd_data};
            r_out.frame_done   <= r_s1_last;
        end
    end

    assign o_out_data = r_out;

endmodule

### src/ttc_checker.sv
`timescale 1ns / 1ps
module ttc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ttc_pkg::t_out_item o_out_data
);
    import ttc_pkg::*;

    // Input stalls only behind a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without a stalled output");

    // A word behind a stalled input is never lost
    a_stall_keeps_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> o_out_valid)
        else $error("output emptied while input was stalled");

    // Stalled output holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output word changed");

    // Reset drops any pending word
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind texture_twiddle_converter ttc_checker u_ttc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
